// ----- rtl/core/mbet_pkg.sv -----
// ============================================================================
// Mandelbrot escape-time package
// Shared widths, constants, the job record and the saturation helper.
// ============================================================================
package mbet_pkg;

    localparam int FRAC_W      = 28;
    localparam int COL_W       = 9;
    localparam int ROW_W       = 8;
    localparam int OFF_W       = 13;
    localparam int STEP_W      = 31;
    localparam int ZOOM_W      = 6;
    localparam int PROD_W      = OFF_W + STEP_W + 1;
    localparam int WIDE_W      = PROD_W + 1;
    localparam int CNT_W       = 10;
    localparam int ITER_W      = 9;
    localparam int INSIDE_W    = 16;
    localparam int SUM_W       = 25;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0]    LIMIT_BASE = CNT_W'(48);
    localparam logic [CNT_W-1:0]    LIMIT_STEP = CNT_W'(12);
    localparam logic [INSIDE_W-1:0] INSIDE_MAX = '1;
    localparam logic [SUM_W-1:0]    ITER_MAX   = '1;
    localparam logic [36:0]         ESC_BOUND  = 37'(4) << FRAC_W;

    typedef enum logic [1:0] {
        REG_CENTER_REAL = 2'd0,
        REG_CENTER_IMAG = 2'd1,
        REG_PIXEL_STEP  = 2'd2,
        REG_ZOOM_LEVEL  = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic [CNT_W-1:0]   limit;
        logic               frame_start;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [31:0] r;
        if (v[WIDE_W-1:31] == '0 || v[WIDE_W-1:31] == '1) begin
            r = v[31:0];
        end else if (v[WIDE_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/mbet_front.sv -----
// ============================================================================
// Mandelbrot front end
// Holds the view registers, maps each pixel to its plane point and limit.
// ============================================================================
module mbet_front #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 200,
    parameter int MAX_LIMIT    = 400
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         pix_valid,
    output logic                         pix_stall,
    input  logic [mbet_pkg::COL_W-1:0]   column,
    input  logic [mbet_pkg::ROW_W-1:0]   row,
    input  logic                         frame_start,
    output logic                         job_valid,
    input  logic                         job_ready,
    output mbet_pkg::job_t               job
);
    import mbet_pkg::*;

    localparam logic signed [OFF_W-1:0] HALF_W = OFF_W'(FRAME_WIDTH / 2);
    localparam logic signed [OFF_W-1:0] HALF_H = OFF_W'(FRAME_HEIGHT / 2);

    logic signed [31:0]       center_real_reg;
    logic signed [31:0]       center_imag_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [ZOOM_W-1:0]        zoom_reg;

    logic                     s1_vld_reg, s1_vld_next;
    logic signed [PROD_W-1:0] prod_re_reg;
    logic signed [PROD_W-1:0] prod_im_reg;
    logic [CNT_W-1:0]         limit_reg;
    logic                     fs_reg;
    logic                     s2_vld_reg, s2_vld_next;
    job_t                     job_reg;

    logic signed [OFF_W-1:0]  col_off;
    logic signed [OFF_W-1:0]  row_off;
    logic signed [31:0]       step_s;
    logic [CNT_W-1:0]         lim_raw;
    logic [CNT_W-1:0]         lim_sel;
    logic                     pix_accept;
    logic                     s1_move;
    logic                     s2_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            center_real_reg <= -32'sd134217728;
            center_imag_reg <= '0;
            step_reg        <= STEP_W'(2684355);
            zoom_reg        <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_CENTER_REAL: center_real_reg <= cfg_data;
                REG_CENTER_IMAG: center_imag_reg <= cfg_data;
                REG_PIXEL_STEP:  step_reg        <= cfg_data[STEP_W-1:0];
                REG_ZOOM_LEVEL:  zoom_reg        <= cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    assign col_off = $signed({{(OFF_W-COL_W){1'b0}}, column}) - HALF_W;
    assign row_off = $signed({{(OFF_W-ROW_W){1'b0}}, row}) - HALF_H;
    assign step_s  = $signed({1'b0, step_reg});
    assign lim_raw = LIMIT_BASE + CNT_W'(zoom_reg) * LIMIT_STEP;
    assign lim_sel = (17'(lim_raw) > 17'(MAX_LIMIT)) ? CNT_W'(MAX_LIMIT) : lim_raw;

    assign s2_take     = s2_vld_reg && job_ready;
    assign s1_move     = s1_vld_reg && (!s2_vld_reg || s2_take);
    assign pix_stall   = s1_vld_reg && !s1_move;
    assign pix_accept  = pix_valid && !pix_stall;
    assign s1_vld_next = pix_accept || (s1_vld_reg && !s1_move);
    assign s2_vld_next = s1_move || (s2_vld_reg && !s2_take);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
        end
    end

    always_ff @(posedge clk) begin
        if (pix_accept) begin
            prod_re_reg <= PROD_W'(col_off) * PROD_W'(step_s);
            prod_im_reg <= PROD_W'(row_off) * PROD_W'(step_s);
            limit_reg   <= lim_sel;
            fs_reg      <= frame_start;
        end
        if (s1_move) begin
            job_reg.cr          <= sat32(WIDE_W'(prod_re_reg) + WIDE_W'(center_real_reg));
            job_reg.ci          <= sat32(WIDE_W'(prod_im_reg) + WIDE_W'(center_imag_reg));
            job_reg.limit       <= limit_reg;
            job_reg.frame_start <= fs_reg;
        end
    end

    assign job_valid = s2_vld_reg;
    assign job       = job_reg;

endmodule

// ----- rtl/core/mbet_queue.sv -----
// ============================================================================
// Mandelbrot job queue
// Short first-in first-out buffer between the front and back ends.
// ============================================================================
module mbet_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  mbet_pkg::job_t wr_job,
    output logic           rd_valid,
    input  logic           rd_ready,
    output mbet_pkg::job_t rd_job
);
    import mbet_pkg::*;

    job_t             entry [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = entry[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry[wr_ptr_reg] <= wr_job;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ----- rtl/core/mbet_back.sv -----
// ============================================================================
// Mandelbrot back end
// Runs the escape iteration, keeps the frame totals and holds the result.
// ============================================================================
module mbet_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  mbet_pkg::job_t                 job,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [mbet_pkg::ITER_W-1:0]    iterations,
    output logic                           inside_res,
    output logic [mbet_pkg::INSIDE_W-1:0]  inside_total,
    output logic [mbet_pkg::SUM_W-1:0]     iteration_total
);
    import mbet_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t          state_reg, state_next;
    logic signed [31:0]   zr_reg, zi_reg;
    logic signed [31:0]   cr_reg, ci_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     limit_reg;
    logic                 fs_reg;
    logic [INSIDE_W-1:0]  inside_cnt_reg, inside_cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 res_valid_reg, res_valid_next;
    logic [ITER_W-1:0]    iterations_reg;
    logic                 inside_res_reg;

    logic signed [63:0]   sq_re, sq_im, cross_prod;
    logic signed [35:0]   zr2, zi2;
    logic signed [36:0]   cross_s;
    logic [36:0]          mag;
    logic                 finished;
    logic                 slot_free;
    logic                 in_set;
    logic [INSIDE_W-1:0]  inside_base;
    logic [SUM_W-1:0]     sum_base;
    logic [SUM_W:0]       sum_wide;

    assign sq_re      = 64'(zr_reg) * 64'(zr_reg);
    assign sq_im      = 64'(zi_reg) * 64'(zi_reg);
    assign cross_prod = 64'(zr_reg) * 64'(zi_reg);
    assign zr2        = $signed(sq_re[63:FRAC_W]);
    assign zi2        = $signed(sq_im[63:FRAC_W]);
    assign cross_s    = $signed(cross_prod[63:FRAC_W-1]);
    assign mag        = {zr2[35], zr2} + {zi2[35], zi2};
    assign finished   = (n_reg == limit_reg) || (mag > ESC_BOUND);

    assign slot_free   = !res_valid_reg || !res_stall;
    assign job_ready   = (state_reg == ST_IDLE);
    assign in_set      = (n_reg == limit_reg);
    assign inside_base = fs_reg ? '0 : inside_cnt_reg;
    assign sum_base    = fs_reg ? '0 : sum_reg;
    assign sum_wide    = {1'b0, sum_base} + (SUM_W+1)'(n_reg);

    always_comb begin
        state_next      = state_reg;
        inside_cnt_next = inside_cnt_reg;
        sum_next        = sum_reg;
        res_valid_next  = res_valid_reg && res_stall;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (finished) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    state_next      = ST_IDLE;
                    res_valid_next  = 1'b1;
                    inside_cnt_next = (in_set && inside_base != INSIDE_MAX)
                                    ? inside_base + 1'b1 : inside_base;
                    sum_next        = (sum_wide > (SUM_W+1)'(ITER_MAX))
                                    ? ITER_MAX : sum_wide[SUM_W-1:0];
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= ST_IDLE;
            inside_cnt_reg <= '0;
            sum_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            inside_cnt_reg <= inside_cnt_next;
            sum_reg        <= sum_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (state_reg == ST_IDLE && job_valid) begin
            cr_reg    <= job.cr;
            ci_reg    <= job.ci;
            limit_reg <= job.limit;
            fs_reg    <= job.frame_start;
            zr_reg    <= '0;
            zi_reg    <= '0;
            n_reg     <= '0;
        end else if (state_reg == ST_RUN && !finished) begin
            zi_reg <= sat32(WIDE_W'(cross_s) + WIDE_W'(ci_reg));
            zr_reg <= sat32(WIDE_W'(zr2) - WIDE_W'(zi2) + WIDE_W'(cr_reg));
            n_reg  <= n_reg + 1'b1;
        end
        if (state_reg == ST_DONE && slot_free) begin
            iterations_reg <= n_reg[ITER_W-1:0];
            inside_res_reg <= in_set;
        end
    end

    assign res_valid       = res_valid_reg;
    assign iterations      = iterations_reg;
    assign inside_res      = inside_res_reg;
    assign inside_total    = inside_cnt_reg;
    assign iteration_total = sum_reg;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> n_reg <= limit_reg)
        else $error("iteration count passed the limit");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && slot_free) |=> (res_valid_reg && state_reg == ST_IDLE))
        else $error("finished pixel did not reach the output register");

    a_inside_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && inside_res_reg) |-> inside_cnt_reg != '0)
        else $error("inside pixel not counted");
`endif

endmodule

// ----- rtl/core/mandelbrot_escape_time_pixel.sv -----
// ============================================================================
// Mandelbrot escape-time pixel evaluator
// Maps a pixel to the plane, counts escape iterations and keeps frame totals.
// ============================================================================
// Throughput: set by the back end's complex square loop, which runs one iteration
// per cycle on one pixel at a time; the front end and queue hold further pixels meanwhile.
// Reset: asynchronous, active low; view registers return to their defaults,
// frame totals clear to zero and all queued or running pixels are dropped.
module mandelbrot_escape_time_pixel #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 200,
    parameter int MAX_LIMIT    = 400
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [1:0]                     cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  logic [mbet_pkg::COL_W-1:0]     column,
    input  logic [mbet_pkg::ROW_W-1:0]     row,
    input  logic                           frame_start,
    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [mbet_pkg::ITER_W-1:0]    iterations,
    output logic                           inside_res,
    output logic [mbet_pkg::INSIDE_W-1:0]  inside_total,
    output logic [mbet_pkg::SUM_W-1:0]     iteration_total
);
    import mbet_pkg::*;

    job_t front_job;
    job_t back_job;
    logic front_valid;
    logic front_ready;
    logic back_valid;
    logic back_ready;

    mbet_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .MAX_LIMIT    (MAX_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .column      (column),
        .row         (row),
        .frame_start (frame_start),
        .job_valid   (front_valid),
        .job_ready   (front_ready),
        .job         (front_job)
    );

    mbet_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_job   (front_job),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_job   (back_job)
    );

    mbet_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (back_valid),
        .job_ready       (back_ready),
        .job             (back_job),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .iterations      (iterations),
        .inside_res      (inside_res),
        .inside_total    (inside_total),
        .iteration_total (iteration_total)
    );

endmodule
